// File: hw/rtl/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// Types, codes and defaults shared by the first-fit region allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

  // Defaults for the top-level parameters
  localparam int HEAP_BYTES_DEF   = 65536;
  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int HEADER_BYTES_DEF = 8;

  // Link field width and the end-of-list mark
  localparam int             LINK_W    = 7;
  localparam logic [LINK_W-1:0] LINK_NONE = 7'd127;

  // Request codes
  localparam logic [1:0] REQ_ALLOC  = 2'd0;
  localparam logic [1:0] REQ_FREE   = 2'd1;
  localparam logic [1:0] REQ_RESIZE = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_TBL_FULL  = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // Configuration register indexes
  localparam logic REG_REGION_BASE = 1'b0;
  localparam logic REG_REGION_SIZE = 1'b1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] req_size;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] result_address;
    logic [16:0] used_bytes;
  } result_t;

  // One block table entry
  typedef struct packed {
    logic [15:0]       offset;
    logic [15:0]       length;
    logic [LINK_W-1:0] link;
  } entry_t;

endpackage

// File: hw/rtl/ffra_slot_find.sv
// ----------------------------------------------------------------------------
// ffra_slot_find
// Lowest free slot of the block table, with a found flag.
// ----------------------------------------------------------------------------
module ffra_slot_find import ffra_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic [MAX_BLOCKS-1:0]         busy_vec,
  output logic                          found,
  output logic [$clog2(MAX_BLOCKS)-1:0] idx
);

  localparam int SW = $clog2(MAX_BLOCKS);

  // scan down so the lowest clear slot wins
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (!busy_vec[i]) begin
        found = 1'b1;
        idx   = SW'(i);
      end
    end
  end

endmodule

// File: hw/rtl/first_fit_region_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_region_allocator
// Region allocator: address-ordered block list in a table memory, first fit.
// ----------------------------------------------------------------------------
// The list is walked one entry per cycle from a registered table read; a resize
//   that moves places a new block, then walks the list again to unlink the old
//   one. One request at a time; busy is high while it runs. done pulses one
//   cycle with the result word; the receiver cannot stall. Config writes are
//   taken only while idle.
// Reset empties the list and clears usage; the table needs no clearing pass.
module first_fit_region_allocator import ffra_pkg::*; #(
  parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
  parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        req,
  output logic        done,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int SW = $clog2(MAX_BLOCKS);
  localparam int AW = 20;
  localparam logic [LINK_W-1:0] MAXB = LINK_W'(MAX_BLOCKS);
  localparam logic [AW-1:0]     HDR  = AW'(HEADER_BYTES);
  localparam logic [AW-1:0]     HEAP = AW'(HEAP_BYTES);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_FIND_CHK = 12'b000000000010,
    S_NXT_CHK  = 12'b000000000100,
    S_PL_START = 12'b000000001000,
    S_PL_FCHK  = 12'b000000010000,
    S_PL_CHK   = 12'b000000100000,
    S_PL_TAIL  = 12'b000001000000,
    S_PL_WR    = 12'b000010000000,
    S_PL_LINK  = 12'b000100000000,
    S_PL_FIN   = 12'b001000000000,
    S_REFIND   = 12'b010000000000,
    S_UNLINK   = 12'b100000000000
  } state_t;

  state_t state;

  // configuration
  logic [31:0] region_base;
  logic [16:0] region_size;

  // allocator state
  logic [LINK_W-1:0]     first;
  logic [MAX_BLOCKS-1:0] slot_busy;
  logic [16:0]           bytes_used;

  // request and walk registers
  logic [1:0]        op;
  logic [15:0]       rq_size;
  logic [31:0]       rq_addr;
  logic              mv;
  logic [SW-1:0]     cur;
  entry_t            cur_e;
  logic [LINK_W-1:0] prev;
  entry_t            prev_e;
  logic [SW-1:0]     slot;
  entry_t            slot_e;
  logic [SW-1:0]     newslot;
  logic [15:0]       new_off;
  logic [LINK_W-1:0] new_next;

  // table memory
  entry_t tbl [MAX_BLOCKS];
  entry_t rdata;
  logic          we;
  logic [SW-1:0] wa;
  logic [SW-1:0] ra;
  entry_t        wd;

  always_ff @(posedge clk) begin
    if (we) begin
      tbl[wa] <= wd;
    end
    rdata <= tbl[ra];
  end

  // free slot
  logic          free_found;
  logic [SW-1:0] free_idx;

  ffra_slot_find #(.MAX_BLOCKS(MAX_BLOCKS)) u_slot_find (
    .busy_vec (slot_busy),
    .found    (free_found),
    .idx      (free_idx)
  );

  // shared arithmetic
  logic [AW-1:0] need, limit, cur_end, grow_lim, tail_end;
  logic [31:0]   key, new_pay;
  logic          first_ok, rd_link_ok, prev_ok, match, shrink;

  assign need       = HDR + AW'(rq_size);
  assign limit      = (AW'(region_size) > HEAP) ? HEAP : AW'(region_size);
  assign cur_end    = AW'(cur_e.offset) + HDR + AW'(cur_e.length);
  assign tail_end   = cur_end + need;
  assign grow_lim   = AW'(slot_e.offset) + HDR + AW'(rq_size);
  assign key        = rq_addr - region_base - 32'(HEADER_BYTES);
  assign new_pay    = region_base + {16'd0, new_off} + 32'(HEADER_BYTES);
  assign first_ok   = first < MAXB;
  assign rd_link_ok = rdata.link < MAXB;
  assign prev_ok    = prev < MAXB;
  assign match      = key == {16'd0, rdata.offset};
  assign shrink     = rq_size < rdata.length;

  assign busy      = state != S_IDLE;
  assign cfg_ready = !busy;

  // table port control
  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = rdata;
    ra = '0;
    unique case (state)
      S_IDLE, S_REFIND: ra = first[SW-1:0];
      S_FIND_CHK: begin
        if (!match) begin
          ra = rdata.link[SW-1:0];
        end else if (op == REQ_RESIZE && !mv) begin
          if (shrink) begin
            we = 1'b1;
            wa = cur;
            wd = rdata;
            wd.length = rq_size;
          end else begin
            ra = rdata.link[SW-1:0];
          end
        end
      end
      S_NXT_CHK: begin
        if (AW'(rdata.offset) > grow_lim) begin
          we = 1'b1;
          wa = slot;
          wd = slot_e;
          wd.length = rq_size;
        end
      end
      S_PL_START: begin
        if (free_found && !first_ok && need <= limit) begin
          we = 1'b1;
          wa = free_idx;
          wd = '{offset: 16'd0, length: rq_size, link: LINK_NONE};
        end else begin
          ra = first[SW-1:0];
        end
      end
      S_PL_FCHK: begin
        if (AW'(rdata.offset) > need) begin
          we = 1'b1;
          wa = newslot;
          wd = '{offset: 16'd0, length: rq_size, link: first};
        end else begin
          ra = rdata.link[SW-1:0];
        end
      end
      S_PL_CHK: ra = rdata.link[SW-1:0];
      S_PL_WR: begin
        we = 1'b1;
        wa = newslot;
        wd = '{offset: new_off, length: rq_size, link: new_next};
      end
      S_PL_LINK: begin
        we = 1'b1;
        wa = cur;
        wd = cur_e;
        wd.link = LINK_W'(newslot);
      end
      S_UNLINK: begin
        if (prev_ok) begin
          we = 1'b1;
          wa = prev[SW-1:0];
          wd = prev_e;
          wd.link = slot_e.link;
        end
      end
      S_PL_TAIL, S_PL_FIN: ;
      default: ;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= '0;
      region_size <= 17'd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_REGION_BASE: region_base <= cfg_data;
        REG_REGION_SIZE: region_size <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      first      <= LINK_NONE;
      slot_busy  <= '0;
      bytes_used <= '0;
      done       <= 1'b0;
      mv         <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op      <= req.req_type;
            rq_size <= req.req_size;
            rq_addr <= req.address;
            mv      <= 1'b0;
            cur     <= first[SW-1:0];
            prev    <= LINK_NONE;
            unique case (req.req_type)
              REQ_ALLOC: state <= S_PL_START;
              REQ_FREE, REQ_RESIZE: begin
                if (first_ok) begin
                  state <= S_FIND_CHK;
                end else begin
                  done   <= 1'b1;
                  result <= '{ST_NOT_FOUND, 32'd0, bytes_used};
                end
              end
              default: begin
                done   <= 1'b1;
                result <= '{ST_OK, 32'd0, bytes_used};
              end
            endcase
          end
        end

        // list walk by address
        S_FIND_CHK: begin
          if (!match) begin
            if (rd_link_ok) begin
              prev   <= LINK_W'(cur);
              prev_e <= rdata;
              cur    <= rdata.link[SW-1:0];
            end else begin
              done   <= 1'b1;
              result <= '{ST_NOT_FOUND, 32'd0, bytes_used};
              state  <= S_IDLE;
            end
          end else begin
            slot   <= cur;
            slot_e <= rdata;
            if (op != REQ_RESIZE || mv) begin
              state <= S_UNLINK;
            end else if (shrink) begin
              bytes_used <= bytes_used - 17'(rdata.length) + 17'(rq_size);
              done   <= 1'b1;
              result <= '{ST_OK,
                         region_base + {16'd0, rdata.offset} + 32'(HEADER_BYTES),
                         bytes_used - 17'(rdata.length) + 17'(rq_size)};
              state  <= S_IDLE;
            end else if (rd_link_ok) begin
              state <= S_NXT_CHK;
            end else begin
              state <= S_PL_START;
            end
          end
        end

        // grow in place if the next block leaves room
        S_NXT_CHK: begin
          if (AW'(rdata.offset) > grow_lim) begin
            bytes_used <= bytes_used - 17'(slot_e.length) + 17'(rq_size);
            done   <= 1'b1;
            result <= '{ST_OK,
                       region_base + {16'd0, slot_e.offset} + 32'(HEADER_BYTES),
                       bytes_used - 17'(slot_e.length) + 17'(rq_size)};
            state  <= S_IDLE;
          end else begin
            state <= S_PL_START;
          end
        end

        // placement: slot check, then empty list or head gap
        S_PL_START: begin
          newslot <= free_idx;
          if (!free_found) begin
            done   <= 1'b1;
            result <= '{ST_TBL_FULL, 32'd0, bytes_used};
            state  <= S_IDLE;
          end else if (!first_ok) begin
            if (need > limit) begin
              done   <= 1'b1;
              result <= '{ST_NO_SPACE, 32'd0, bytes_used};
              state  <= S_IDLE;
            end else begin
              first      <= LINK_W'(free_idx);
              slot_busy[free_idx] <= 1'b1;
              bytes_used <= bytes_used + need[16:0];
              new_off    <= '0;
              state      <= S_PL_FIN;
            end
          end else begin
            state <= S_PL_FCHK;
          end
        end

        S_PL_FCHK: begin
          if (AW'(rdata.offset) > need) begin
            first      <= LINK_W'(newslot);
            slot_busy[newslot] <= 1'b1;
            bytes_used <= bytes_used + need[16:0];
            new_off    <= '0;
            state      <= S_PL_FIN;
          end else begin
            cur   <= first[SW-1:0];
            cur_e <= rdata;
            state <= rd_link_ok ? S_PL_CHK : S_PL_TAIL;
          end
        end

        // gap walk: rdata is the block after cur
        S_PL_CHK: begin
          if (AW'(rdata.offset) < tail_end) begin
            cur   <= cur_e.link[SW-1:0];
            cur_e <= rdata;
            if (!rd_link_ok) begin
              state <= S_PL_TAIL;
            end
          end else begin
            new_off  <= cur_end[15:0];
            new_next <= cur_e.link;
            state    <= S_PL_WR;
          end
        end

        S_PL_TAIL: begin
          if (tail_end > limit) begin
            done   <= 1'b1;
            result <= '{ST_NO_SPACE, 32'd0, bytes_used};
            state  <= S_IDLE;
          end else begin
            new_off  <= cur_end[15:0];
            new_next <= LINK_NONE;
            state    <= S_PL_WR;
          end
        end

        S_PL_WR: state <= S_PL_LINK;

        S_PL_LINK: begin
          slot_busy[newslot] <= 1'b1;
          bytes_used <= bytes_used + need[16:0];
          state      <= S_PL_FIN;
        end

        S_PL_FIN: begin
          if (op == REQ_RESIZE) begin
            mv    <= 1'b1;
            state <= S_REFIND;
          end else begin
            done   <= 1'b1;
            result <= '{ST_OK, new_pay, bytes_used};
            state  <= S_IDLE;
          end
        end

        // second walk to unlink the moved block
        S_REFIND: begin
          cur   <= first[SW-1:0];
          prev  <= LINK_NONE;
          state <= S_FIND_CHK;
        end

        S_UNLINK: begin
          if (!prev_ok) begin
            first <= slot_e.link;
          end
          slot_busy[slot] <= 1'b0;
          bytes_used <= bytes_used - 17'(HEADER_BYTES) - 17'(slot_e.length);
          done   <= 1'b1;
          result <= '{ST_OK, mv ? new_pay : 32'd0,
                     bytes_used - 17'(HEADER_BYTES) - 17'(slot_e.length)};
          state  <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
